// ===== hdl/fdm_pkg.sv =====
// ----------------------------------------------------------------------------
// fdm_pkg
// Shared widths, limits, sequencer states and status types for the field
// difference measure block.
// ----------------------------------------------------------------------------
package fdm_pkg;

    localparam int LUMA_W      = 8;
    localparam int SHIFT_W     = 4;
    localparam int SQ_W        = 2 * LUMA_W;
    localparam int PAIR_W      = SQ_W + 1;
    localparam int LINE_SUM_W  = 27;
    localparam int ROOT_W      = (LINE_SUM_W + 1) / 2;
    localparam int REM_W       = ROOT_W + 2;
    localparam int ROOT_CNT_W  = 4;
    localparam int FIELD_SUM_W = 22;

    localparam logic [SHIFT_W-1:0]     BIT_SHIFT_RESET = 4'd13;
    localparam logic [LINE_SUM_W-1:0]  LINE_SUM_MAX    = {LINE_SUM_W{1'b1}};
    localparam logic [FIELD_SUM_W-1:0] FIELD_SUM_MAX   = 22'd4177920;
    localparam logic [ROOT_CNT_W-1:0]  ROOT_LAST       = 4'(ROOT_W - 1);

    // Sequencer states of the per-item flow.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_A,
        ST_SQ_B,
        ST_ACC,
        ST_ROOT,
        ST_OUT
    } fdm_state_t;

    // Status of the iterative square root unit.
    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_status_t;

endpackage

// ===== hdl/fdm_sqrt.sv =====
// ----------------------------------------------------------------------------
// fdm_sqrt
// Iterative floor square root: one result bit per cycle, digit by digit.
// ----------------------------------------------------------------------------
module fdm_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [fdm_pkg::LINE_SUM_W-1:0] operand,
    output fdm_pkg::sqrt_status_t          status,
    output logic [fdm_pkg::ROOT_W-1:0]     root
);
    import fdm_pkg::*;

    localparam int OP_W = 2 * ROOT_W;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [ROOT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;

    logic [REM_W+1:0]      rem_sh;
    logic [REM_W+1:0]      trial;
    logic [REM_W+1:0]      rem_sub;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    // One trial subtraction per cycle on the next two operand bits.
    assign rem_sh  = {rem_reg, op_reg[OP_W-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign rem_sub = rem_sh - trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            op_next   = OP_W'(operand);
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            op_next = {op_reg[OP_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sub[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ROOT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign root        = root_reg;

endmodule

// ===== hdl/fdm_seq.sv =====
// ----------------------------------------------------------------------------
// fdm_seq
// Sequencer and accumulators: shared squarer, line and field sums, result
// register.
// ----------------------------------------------------------------------------
module fdm_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [fdm_pkg::SHIFT_W-1:0]     bit_shift,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [fdm_pkg::LUMA_W-1:0]      prev_luma_a,
    input  logic [fdm_pkg::LUMA_W-1:0]      prev_luma_b,
    input  logic [fdm_pkg::LUMA_W-1:0]      cur_luma_a,
    input  logic [fdm_pkg::LUMA_W-1:0]      cur_luma_b,
    input  logic                            line_end,
    input  logic                            field_end,
    output logic                            sqrt_start,
    output logic [fdm_pkg::LINE_SUM_W-1:0]  sqrt_operand,
    input  fdm_pkg::sqrt_status_t           sqrt_status,
    input  logic [fdm_pkg::ROOT_W-1:0]      sqrt_root,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fdm_pkg::FIELD_SUM_W-1:0] out_data
);
    import fdm_pkg::*;

    fdm_state_t             state_reg, state_next;
    logic [LINE_SUM_W-1:0]  line_sum_reg, line_sum_next;
    logic [FIELD_SUM_W-1:0] field_sum_reg, field_sum_next;
    logic                   out_valid_reg, out_valid_next;
    logic [FIELD_SUM_W-1:0] out_data_reg, out_data_next;

    logic [LUMA_W-1:0]      pa_reg, pb_reg, ca_reg, cb_reg;
    logic                   eol_reg, eof_reg;
    logic [SQ_W-1:0]        sq_a_reg, sq_a_next;
    logic [SQ_W-1:0]        sq_b_reg, sq_b_next;

    logic [LUMA_W-1:0]      mul_x, mul_y, diff;
    logic [SQ_W-1:0]        prod;
    logic [PAIR_W-1:0]      pair;
    logic [LINE_SUM_W:0]    line_add;
    logic [LINE_SUM_W-1:0]  line_sat;
    logic [FIELD_SUM_W:0]   field_add;
    logic [FIELD_SUM_W-1:0] field_sat;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            line_sum_reg  <= '0;
            field_sum_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            line_sum_reg  <= line_sum_next;
            field_sum_reg <= field_sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item capture, products and result payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pa_reg  <= prev_luma_a;
            pb_reg  <= prev_luma_b;
            ca_reg  <= cur_luma_a;
            cb_reg  <= cur_luma_b;
            eol_reg <= line_end;
            eof_reg <= field_end;
        end
        sq_a_reg     <= sq_a_next;
        sq_b_reg     <= sq_b_next;
        out_data_reg <= out_data_next;
    end

    // Shared squarer: sample a in one cycle, sample b in the next.
    always_comb
    begin
        if (state_reg == ST_SQ_A)
        begin
            mul_x = pa_reg;
            mul_y = ca_reg;
        end
        else
        begin
            mul_x = pb_reg;
            mul_y = cb_reg;
        end
        diff = (mul_x >= mul_y) ? (mul_x - mul_y) : (mul_y - mul_x);
        prod = diff * diff;
    end

    // Pair value, saturating line add and saturating field add.
    always_comb
    begin
        pair      = ({1'b0, sq_a_reg} + {1'b0, sq_b_reg}) >> bit_shift;
        line_add  = {1'b0, line_sum_reg} + (LINE_SUM_W + 1)'(pair);
        line_sat  = line_add[LINE_SUM_W] ? LINE_SUM_MAX : line_add[LINE_SUM_W-1:0];
        field_add = {1'b0, field_sum_reg} + (FIELD_SUM_W + 1)'(sqrt_root);
        field_sat = (field_add > {1'b0, FIELD_SUM_MAX}) ? FIELD_SUM_MAX
                                                        : field_add[FIELD_SUM_W-1:0];
    end

    // Next state and outputs.
    always_comb
    begin
        state_next     = state_reg;
        line_sum_next  = line_sum_reg;
        field_sum_next = field_sum_reg;
        sq_a_next      = sq_a_reg;
        sq_b_next      = sq_b_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        sqrt_start     = 1'b0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_SQ_A;
                end
            end
            ST_SQ_A:
            begin
                sq_a_next  = prod;
                state_next = ST_SQ_B;
            end
            ST_SQ_B:
            begin
                sq_b_next  = prod;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (eol_reg || eof_reg)
                begin
                    // Close the line: the root unit takes the final line sum.
                    sqrt_start    = 1'b1;
                    line_sum_next = '0;
                    state_next    = ST_ROOT;
                end
                else
                begin
                    line_sum_next = line_sat;
                    state_next    = ST_IDLE;
                end
            end
            ST_ROOT:
            begin
                if (sqrt_status.done)
                begin
                    field_sum_next = field_sat;
                    state_next     = eof_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT:
            begin
                // Wait until the result register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = field_sum_reg;
                    field_sum_next = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign sqrt_operand = line_sat;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

endmodule

// ===== hdl/field_difference_measure.sv =====
// Flow: an item without marks passes ST_SQ_A, ST_SQ_B and ST_ACC before ready again.
// An item with a line or field end adds the 14-step square root unit and the field
// fold; a field end adds ST_OUT to load the result register, and waits
// longer while an earlier result is still held there.
// A new item is taken only in ST_IDLE, once the last one is through.
// Reset: rst_n is asynchronous, active low; sums clear and bit_shift becomes 13.
// ----------------------------------------------------------------------------
// field_difference_measure
// Sum over a field's lines of the floor square root of each line's sum of per-pair
// shifted squared luma differences against the previous same-parity field.
// ----------------------------------------------------------------------------
module field_difference_measure (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // prev_luma_a [7:0], prev_luma_b [15:8], cur_luma_a [23:16], cur_luma_b [31:24]
    input  logic [31:0] s_axis_tdata,
    // line_end [0]
    input  logic [0:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // field_difference [21:0], zero [23:22]
    output logic [23:0] m_axis_tdata,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data
);
    import fdm_pkg::*;

    logic [SHIFT_W-1:0]     bit_shift_reg;
    logic                   sqrt_start;
    logic [LINE_SUM_W-1:0]  sqrt_operand;
    sqrt_status_t           sqrt_status;
    logic [ROOT_W-1:0]      sqrt_root;
    logic [FIELD_SUM_W-1:0] result;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_shift_reg <= BIT_SHIFT_RESET;
        end
        else if (cfg_wr_en)
        begin
            bit_shift_reg <= cfg_wr_data;
        end
    end

    // Sequencer with the shared squarer and the accumulators.
    fdm_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .bit_shift    (bit_shift_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .prev_luma_a  (s_axis_tdata[7:0]),
        .prev_luma_b  (s_axis_tdata[15:8]),
        .cur_luma_a   (s_axis_tdata[23:16]),
        .cur_luma_b   (s_axis_tdata[31:24]),
        .line_end     (s_axis_tuser[0]),
        .field_end    (s_axis_tlast),
        .sqrt_start   (sqrt_start),
        .sqrt_operand (sqrt_operand),
        .sqrt_status  (sqrt_status),
        .sqrt_root    (sqrt_root),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (result)
    );

    // Iterative square root of each closed line.
    fdm_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (sqrt_operand),
        .status  (sqrt_status),
        .root    (sqrt_root)
    );

    assign m_axis_tdata = {2'b00, result};

    // The root unit never runs while a new item could be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_status.busy |-> !s_axis_tready)
        else $error("input ready while square root is running");

    // Input ready is never high again directly after a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready again directly after an input transfer");

    // A presented result never exceeds the saturation bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[21:0] <= FIELD_SUM_MAX))
        else $error("field difference above its saturation bound");

    // A square root is only started when the unit is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |-> !sqrt_status.busy)
        else $error("square root restarted while busy");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for field_difference_measure. A queue-fed driver sends
// pixel pairs, an in-bench model of the line and field accumulators predicts
// each field total, and a monitor compares the totals as they come out.
// Phases vary bit_shift and the idle rates on both streams and include a long
// output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    import fdm_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    // One pixel pair with its line and field marks.
    typedef struct packed {
        logic [LUMA_W-1:0] prev_a;
        logic [LUMA_W-1:0] prev_b;
        logic [LUMA_W-1:0] cur_a;
        logic [LUMA_W-1:0] cur_b;
        logic              line_end;
        logic              field_end;
    } pixel_pair_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [3:0]  cfg_wr_data = '0;

    pixel_pair_t pair_q[$];
    logic [FIELD_SUM_W-1:0] field_total_q[$];

    // Bench copy of the block state.
    logic [SHIFT_W-1:0]    shift_cfg = BIT_SHIFT_RESET;
    logic [LINE_SUM_W-1:0] line_acc = '0;
    logic [22:0]           field_acc = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int err_cnt = 0;
    int cycle_cnt = 0;

    field_difference_measure dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // Clock with a period of 4.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Squared distance of two luma samples.
    function automatic logic [SQ_W-1:0] luma_dist_sq(input logic [LUMA_W-1:0] a,
                                                      input logic [LUMA_W-1:0] b);
        logic [LUMA_W-1:0] d;
        d = (a >= b) ? a - b : b - a;
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    // Floor square root, built one result bit at a time from the top.
    function automatic logic [ROOT_W-1:0] floor_root(input logic [LINE_SUM_W-1:0] v);
        logic [ROOT_W-1:0] r;
        r = '0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            r[b] = 1'b1;
            if (({{ROOT_W{1'b0}}, r} * {{ROOT_W{1'b0}}, r}) > {1'b0, v})
                r[b] = 1'b0;
        end
        return r;
    endfunction

    // Advance the accumulators by one accepted pair and queue any field total.
    function automatic void accumulate_pair(input pixel_pair_t p);
        logic [PAIR_W-1:0]     pair_val;
        logic [LINE_SUM_W:0]   line_next;
        logic [23:0]           field_next;
        pair_val = ({1'b0, luma_dist_sq(p.prev_a, p.cur_a)}
                    + {1'b0, luma_dist_sq(p.prev_b, p.cur_b)}) >> shift_cfg;
        line_next = {1'b0, line_acc} + (LINE_SUM_W + 1)'(pair_val);
        line_acc = (line_next > {1'b0, LINE_SUM_MAX}) ? LINE_SUM_MAX
                                                      : line_next[LINE_SUM_W-1:0];
        if (p.line_end || p.field_end)
        begin
            field_next = {1'b0, field_acc} + 24'(floor_root(line_acc));
            field_acc = (field_next > 24'(FIELD_SUM_MAX)) ? 23'(FIELD_SUM_MAX)
                                                          : field_next[22:0];
            line_acc = '0;
        end
        if (p.field_end)
        begin
            field_total_q.push_back(field_acc[FIELD_SUM_W-1:0]);
            field_acc = '0;
        end
    endfunction

    // Input driver: predicts on each transfer, then offers the next pair.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                accumulate_pair('{s_axis_tdata[7:0], s_axis_tdata[15:8],
                                  s_axis_tdata[23:16], s_axis_tdata[31:24],
                                  s_axis_tuser[0], s_axis_tlast});
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pair_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    pixel_pair_t p;
                    p = pair_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {p.cur_b, p.cur_a, p.prev_b, p.prev_a};
                    s_axis_tuser  <= p.line_end;
                    s_axis_tlast  <= p.field_end;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long output hold-off, counted down in cycles.
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Output ready with random stalls.
    always @(posedge clk)
    begin
        m_axis_tready <= rst_n && (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    // Output monitor: compare each transfer with the oldest predicted total.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (field_total_q.size() == 0)
            begin
                err_cnt <= err_cnt + 1;
                if (err_cnt < MAX_REPORTS)
                    $display("Unexpected field total %0d", m_axis_tdata[FIELD_SUM_W-1:0]);
            end
            else
            begin
                logic [FIELD_SUM_W-1:0] want;
                want = field_total_q.pop_front();
                if (m_axis_tdata[FIELD_SUM_W-1:0] !== want)
                begin
                    err_cnt <= err_cnt + 1;
                    if (err_cnt < MAX_REPORTS)
                        $display("Field total mismatch: expected %0d, got %0d",
                                 want, m_axis_tdata[FIELD_SUM_W-1:0]);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Luma value biased toward the range ends.
    function automatic logic [LUMA_W-1:0] pick_luma();
        int roll;
        roll = $urandom_range(7);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return '1;
        return LUMA_W'($urandom);
    endfunction

    function automatic pixel_pair_t make_pair(input logic [LUMA_W-1:0] pa, pb, ca, cb,
                                              input logic le, fe);
        pixel_pair_t p;
        p = '{pa, pb, ca, cb, le, fe};
        return p;
    endfunction

    // Queue random fields of short lines until about n pairs are queued.
    task automatic queue_random_fields(input int n);
        int count;
        int lines;
        int len;
        logic le;
        logic fe;
        count = 0;
        while (count < n)
        begin
            lines = $urandom_range(1, 5);
            for (int l = 0; l < lines; l++)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                begin
                    le = (i == len - 1);
                    fe = (i == len - 1) && (l == lines - 1);
                    // Occasionally close the field without a line mark, or
                    // drop a stray mark in mid-line.
                    if (fe && $urandom_range(4) == 0)
                        le = 1'b0;
                    if (!le && $urandom_range(29) == 0)
                        le = 1'b1;
                    if (!fe && $urandom_range(59) == 0)
                        fe = 1'b1;
                    pair_q.push_back(make_pair(pick_luma(), pick_luma(), pick_luma(),
                                               pick_luma(), le, fe));
                    count++;
                end
            end
        end
    endtask

    // Wait until every queued pair is sent and every total has arrived,
    // then let the block finish any pair that produces no total.
    task automatic wait_drained();
        while (pair_q.size() != 0 || s_axis_tvalid || field_total_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_shift(input logic [SHIFT_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        shift_cfg = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_random_phase(input logic [SHIFT_W-1:0] shift, input int s_pct,
                                    input int r_pct, input int n);
        wait_drained();
        write_shift(shift);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        queue_random_fields(n);
        wait_drained();
    endtask

    // Main sequence.
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed pairs under the reset shift, then with no shift.
        for (int k = 0; k < 2; k++)
        begin
            if (k == 1)
                write_shift(4'd0);
            pair_q.push_back(make_pair(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
            pair_q.push_back(make_pair(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0));
            pair_q.push_back(make_pair(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b1, 1'b0));
            pair_q.push_back(make_pair(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b1));
            pair_q.push_back(make_pair(8'h80, 8'h7F, 8'h7F, 8'h80, 1'b1, 1'b1));
            pair_q.push_back(make_pair(8'h55, 8'hAA, 8'hAA, 8'h55, 1'b1, 1'b0));
            pair_q.push_back(make_pair(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b1, 1'b1));
            pair_q.push_back(make_pair(8'h3C, 8'hC3, 8'h3C, 8'hC3, 1'b1, 1'b1));
            pair_q.push_back(make_pair(8'h01, 8'hFE, 8'h10, 8'hEF, 1'b0, 1'b1));
            wait_drained();
        end

        // Random phases across shifts and idle patterns.
        run_random_phase(4'd15, 0,  0,  95);
        run_random_phase(4'd0,  79, 0,  95);
        run_random_phase(4'd4,  0,  79, 95);
        run_random_phase(4'd7,  23, 23, 95);
        run_random_phase(4'd2,  0,  0,  95);
        run_random_phase(4'd10, 79, 0,  90);
        run_random_phase(4'd1,  0,  79, 90);
        run_random_phase(4'd5,  23, 23, 90);

        // Output held off while short fields keep arriving at full rate.
        wait_drained();
        write_shift(4'd3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 40; i++)
            pair_q.push_back(make_pair(pick_luma(), pick_luma(), pick_luma(), pick_luma(),
                                       1'b1, ($urandom_range(1) == 1)));
        hold_left = 600;
        wait_drained();

        if (err_cnt == 0 && field_total_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
